// ===== rtl/tpli_pkg.sv =====
// Shared types and constants for the two-point line intersection block.
package tpli_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_S1,
    ST_S2,
    ST_CMP,
    ST_B1,
    ST_B2,
    ST_M3,
    ST_M4,
    ST_NY,
    ST_CX,
    ST_CY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic done;
    logic over;
  } div_stat_t;

  typedef struct packed {
    logic same_slope;
    logic user_vertical;
    logic hit;
  } flags_t;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] REG_START_X = 2'd0;
  localparam logic [1:0] REG_START_Y = 2'd1;
  localparam logic [1:0] REG_END_X   = 2'd2;
  localparam logic [1:0] REG_END_Y   = 2'd3;

  localparam int RST_START_X = 100;
  localparam int RST_START_Y = 300;
  localparam int RST_END_X   = 860;
  localparam int RST_END_Y   = 300;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int RES_W  = 32;
  localparam int OUT_DW = 2 * RES_W;
  localparam int OUT_UW = 3;

endpackage

// ===== rtl/tpli_div.sv =====
// Restoring divider, one quotient bit per cycle, with sticky quotient overflow.
module tpli_div #(
  parameter int NW   = 55,
  parameter int DW   = 29,
  parameter int QW   = 32,
  parameter int LENW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NW-1:0]       num,
  input  logic [DW-1:0]       den,
  input  logic [LENW-1:0]     len,
  output logic [QW-1:0]       q,
  output tpli_pkg::div_stat_t stat
);

  logic            busy_r;
  logic            done_r;
  logic [NW-1:0]   num_r;
  logic [DW-1:0]   den_r;
  logic [DW-1:0]   rem_r;
  logic [QW-1:0]   q_r;
  logic            over_r;
  logic [LENW-1:0] cnt_r;

  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_diff;
  logic            ge;
  logic [DW-1:0]   rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, num_r[NW-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    rem_nxt  = ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == LENW'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= num;
      den_r  <= den;
      cnt_r  <= len;
      rem_r  <= '0;
      q_r    <= '0;
      over_r <= 1'b0;
    end else if (busy_r) begin
      num_r  <= {num_r[NW-2:0], 1'b0};
      cnt_r  <= cnt_r - LENW'(1);
      rem_r  <= rem_nxt;
      q_r    <= {q_r[QW-2:0], ge};
      over_r <= over_r | q_r[QW-1];
    end
  end

  assign q         = q_r;
  assign stat.done = done_r;
  assign stat.over = over_r;

endmodule

// ===== rtl/tpli_mul.sv =====
// Unsigned multiplier with a registered product.
module tpli_mul #(
  parameter int AW = 28,
  parameter int BW = 26
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  logic [AW+BW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= (AW+BW)'(a) * (AW+BW)'(b);
  end

  assign p = p_r;

endmodule

// ===== rtl/two_point_line_intersection.sv =====
// Top level: point intake, fixed-line registers, sequencer and result register.
//
// Input channel (in_*): one point per transfer; in_tuser is the operation
// (new point or clear). A clear or the first point of a pair is absorbed
// while the block stays idle, so in_tready stays high. The second point
// of a pair produces one result on the out_* channel; in_tready stays low
// until that result sits in the output register.
// When either line is vertical the block skips all arithmetic; when the
// slopes match it stops after the two slopes. The latency of a pair is set
// by the shared one-bit-per-cycle divider, which runs the user slope, the
// fixed slope, cross_x and cross_y one after another, and by the shared
// multiplier used for both intercepts and both cross products.
// The result waits in the output register while out_tready is low; a new
// clear or first point is still taken meanwhile, but a further pair holds
// in its last step until the register frees.
// Reset (synchronous, active low) forgets the stored point, empties the
// output register and loads the fixed line from (100,300) to (860,300).
// Configuration is an APB-style port; write it only while idle.
module two_point_line_intersection #(
  parameter int COORD_BITS      = 12,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata fields from bit 0: point_x, point_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  // in_tuser fields from bit 0: operation
  input  logic                                  in_tuser,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // out_tdata fields from bit 0: cross_x, cross_y
  output logic [tpli_pkg::OUT_DW-1:0]           out_tdata,
  // out_tuser fields from bit 0: hit, user_vertical, same_slope
  output logic [tpli_pkg::OUT_UW-1:0]           out_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [tpli_pkg::CFG_AW-1:0]           cfg_paddr,
  input  logic [tpli_pkg::CFG_DW-1:0]           cfg_pwdata,
  output logic [tpli_pkg::CFG_DW-1:0]           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int C    = COORD_BITS;
  localparam int F    = SLOPE_FRAC_BITS;
  localparam int SM   = C + F;
  localparam int SW   = SM + 1;
  localparam int BW   = (2*C + 2 > 32) ? 32 : 2*C + 2;
  localparam int TW   = SM + C + 2;
  localparam int RW   = TW - F;
  localparam int LW   = (RW > 32) ? RW : 32;
  localparam int PW   = SM + BW + 1;
  localparam int NW   = PW;
  localparam int DW   = SW;
  localparam int QW   = (SM > 32) ? SM : 32;
  localparam int LENW = $clog2(NW + 1);
  localparam int RW32 = tpli_pkg::RES_W;

  tpli_pkg::state_t state_r, state_nxt;

  logic [C-1:0] fsx_r, fsy_r, fex_r, fey_r;
  logic         have_first_r;
  logic [C-1:0] fx_r, fy_r, px_r, py_r;

  logic [SW-1:0]   s1_r, s2_r;
  logic [BW-1:0]   b1_r, b2_r;
  logic [PW-1:0]   p1_r;
  logic            ny_neg_r;
  logic [NW-1:0]   ny_mag_r;
  logic            div_neg_r;
  logic            hit_r, uvert_r, same_r;
  logic [RW32-1:0] cx_r, cy_r;

  logic                      out_valid_r;
  logic [tpli_pkg::OUT_DW-1:0] out_data_r;
  tpli_pkg::flags_t          out_flags_r;

  logic in_acc, cfg_we, out_load;
  logic uvert, fvert;

  // divider and multiplier hookup
  logic                div_start;
  logic [NW-1:0]       div_num;
  logic [DW-1:0]       div_den;
  logic [LENW-1:0]     div_len;
  logic                div_neg_nxt;
  logic [QW-1:0]       div_q;
  tpli_pkg::div_stat_t div_stat;
  logic [SM-1:0]       mul_a;
  logic [BW-1:0]       mul_b;
  logic [SM+BW-1:0]    mul_p;

  // slope operands
  logic         sel_cfg;
  logic [C-1:0] ax, ay, bx, by;
  logic [C:0]   dxv, dyv;
  logic [C-1:0] dx_mag, dy_mag;

  // magnitudes and differences
  logic [SM-1:0] s1_mag, s2_mag;
  logic [BW-1:0] b1_mag, b2_mag;
  logic [SW:0]   den_v;
  logic [DW-1:0] den_mag;
  logic [BW:0]   d_v;
  logic [BW-1:0] d_mag;

  // intercept path
  logic [SW-1:0] ic_s;
  logic [C-1:0]  ic_y;
  logic [TW-1:0] ic_ybig, ic_prod, ic_t, ic_tmag;
  logic [LW-1:0] ic_r, ic_lim, ic_rsat;
  logic [BW-1:0] ic_b;

  // product path
  logic          p_neg;
  logic [PW-1:0] p_val;
  logic [NW:0]   ny_v;

  // quotient post-processing
  logic [SW-1:0]   q_slope;
  logic [QW-1:0]   q_lim, q_sat;
  logic [RW32-1:0] q_res;

  assign in_acc     = in_tvalid & in_tready;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;
  assign uvert      = (fx_r == px_r);
  assign fvert      = (fsx_r == fex_r);

  always_comb begin
    case (cfg_paddr[3:2])
      tpli_pkg::REG_START_X: cfg_prdata = tpli_pkg::CFG_DW'(fsx_r);
      tpli_pkg::REG_START_Y: cfg_prdata = tpli_pkg::CFG_DW'(fsy_r);
      tpli_pkg::REG_END_X:   cfg_prdata = tpli_pkg::CFG_DW'(fex_r);
      tpli_pkg::REG_END_Y:   cfg_prdata = tpli_pkg::CFG_DW'(fey_r);
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsx_r <= C'(tpli_pkg::RST_START_X);
      fsy_r <= C'(tpli_pkg::RST_START_Y);
      fex_r <= C'(tpli_pkg::RST_END_X);
      fey_r <= C'(tpli_pkg::RST_END_Y);
    end else if (cfg_we) begin
      case (cfg_paddr[3:2])
        tpli_pkg::REG_START_X: fsx_r <= cfg_pwdata[C-1:0];
        tpli_pkg::REG_START_Y: fsy_r <= cfg_pwdata[C-1:0];
        tpli_pkg::REG_END_X:   fex_r <= cfg_pwdata[C-1:0];
        tpli_pkg::REG_END_Y:   fey_r <= cfg_pwdata[C-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sel_cfg = (state_r == tpli_pkg::ST_S1);
    ax      = sel_cfg ? fsx_r : fx_r;
    ay      = sel_cfg ? fsy_r : fy_r;
    bx      = sel_cfg ? fex_r : px_r;
    by      = sel_cfg ? fey_r : py_r;
    dxv     = {1'b0, bx} - {1'b0, ax};
    dyv     = {1'b0, by} - {1'b0, ay};
    dx_mag  = dxv[C] ? C'(-dxv) : dxv[C-1:0];
    dy_mag  = dyv[C] ? C'(-dyv) : dyv[C-1:0];

    s1_mag  = s1_r[SW-1] ? SM'(-s1_r) : s1_r[SM-1:0];
    s2_mag  = s2_r[SW-1] ? SM'(-s2_r) : s2_r[SM-1:0];
    b1_mag  = b1_r[BW-1] ? (-b1_r) : b1_r;
    b2_mag  = b2_r[BW-1] ? (-b2_r) : b2_r;

    den_v   = {s1_r[SW-1], s1_r} - {s2_r[SW-1], s2_r};
    den_mag = den_v[SW] ? DW'(-den_v) : den_v[DW-1:0];
    d_v     = {b2_r[BW-1], b2_r} - {b1_r[BW-1], b1_r};
    d_mag   = d_v[BW] ? BW'(-d_v) : d_v[BW-1:0];
  end

  always_comb begin
    ic_s    = (state_r == tpli_pkg::ST_B1) ? s1_r : s2_r;
    ic_y    = (state_r == tpli_pkg::ST_B1) ? fy_r : fsy_r;
    ic_ybig = TW'({ic_y, {F{1'b0}}});
    ic_prod = TW'(mul_p[SM+C-1:0]);
    ic_t    = ic_s[SW-1] ? (ic_ybig + ic_prod) : (ic_ybig - ic_prod);
    ic_tmag = ic_t[TW-1] ? (-ic_t) : ic_t;
    ic_r    = LW'(ic_tmag[TW-1:F]);
    ic_lim  = LW'({ic_t[TW-1], {31{~ic_t[TW-1]}}});
    ic_rsat = (ic_r > ic_lim) ? ic_lim : ic_r;
    ic_b    = ic_t[TW-1] ? (-ic_rsat[BW-1:0]) : ic_rsat[BW-1:0];
  end

  always_comb begin
    p_neg = (state_r == tpli_pkg::ST_M4) ? (s1_r[SW-1] ^ b2_r[BW-1])
                                         : (s2_r[SW-1] ^ b1_r[BW-1]);
    p_val = p_neg ? (-PW'(mul_p)) : PW'(mul_p);
    ny_v  = {p1_r[PW-1], p1_r} - {p_val[PW-1], p_val};
  end

  always_comb begin
    q_slope = div_neg_r ? (-SW'(div_q[SM-1:0])) : SW'(div_q[SM-1:0]);
    q_lim   = QW'({div_neg_r, {31{~div_neg_r}}});
    q_sat   = (div_stat.over || (div_q > q_lim)) ? q_lim : div_q;
    q_res   = div_neg_r ? (-q_sat[RW32-1:0]) : q_sat[RW32-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpli_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser == tpli_pkg::OP_POINT) && have_first_r) begin
          state_nxt = tpli_pkg::ST_CHK;
        end
      end
      tpli_pkg::ST_CHK: state_nxt = (uvert || fvert) ? tpli_pkg::ST_OUT : tpli_pkg::ST_S1;
      tpli_pkg::ST_S1:  if (div_stat.done) state_nxt = tpli_pkg::ST_S2;
      tpli_pkg::ST_S2:  if (div_stat.done) state_nxt = tpli_pkg::ST_CMP;
      tpli_pkg::ST_CMP: state_nxt = (s1_r == s2_r) ? tpli_pkg::ST_OUT : tpli_pkg::ST_B1;
      tpli_pkg::ST_B1:  state_nxt = tpli_pkg::ST_B2;
      tpli_pkg::ST_B2:  state_nxt = tpli_pkg::ST_M3;
      tpli_pkg::ST_M3:  state_nxt = tpli_pkg::ST_M4;
      tpli_pkg::ST_M4:  state_nxt = tpli_pkg::ST_NY;
      tpli_pkg::ST_NY:  state_nxt = tpli_pkg::ST_CX;
      tpli_pkg::ST_CX:  if (div_stat.done) state_nxt = tpli_pkg::ST_CY;
      tpli_pkg::ST_CY:  if (div_stat.done) state_nxt = tpli_pkg::ST_OUT;
      tpli_pkg::ST_OUT: if (out_load) state_nxt = tpli_pkg::ST_IDLE;
      default:          state_nxt = tpli_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = (state_r == tpli_pkg::ST_IDLE);
    out_load    = (state_r == tpli_pkg::ST_OUT) && (!out_valid_r || out_tready);
    div_start   = 1'b0;
    div_num     = {dy_mag, {(NW-C){1'b0}}};
    div_den     = DW'(dx_mag);
    div_len     = LENW'(SM);
    div_neg_nxt = dxv[C] ^ dyv[C];
    mul_a       = '0;
    mul_b       = '0;
    case (state_r)
      tpli_pkg::ST_CHK: div_start = !(uvert || fvert);
      tpli_pkg::ST_S1:  div_start = div_stat.done;
      tpli_pkg::ST_CMP: begin
        mul_a = s1_mag;
        mul_b = BW'(fx_r);
      end
      tpli_pkg::ST_B1: begin
        mul_a = s2_mag;
        mul_b = BW'(fsx_r);
      end
      tpli_pkg::ST_M3: begin
        mul_a = s1_mag;
        mul_b = b2_mag;
      end
      tpli_pkg::ST_M4: begin
        mul_a = s2_mag;
        mul_b = b1_mag;
      end
      tpli_pkg::ST_NY: begin
        div_start   = 1'b1;
        div_num     = {d_mag, {(NW-BW){1'b0}}};
        div_den     = den_mag;
        div_len     = LENW'(BW + F);
        div_neg_nxt = d_v[BW] ^ den_v[SW];
      end
      tpli_pkg::ST_CX: begin
        div_start   = div_stat.done;
        div_num     = ny_mag_r;
        div_den     = den_mag;
        div_len     = LENW'(NW);
        div_neg_nxt = ny_neg_r ^ den_v[SW];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tpli_pkg::ST_IDLE;
      have_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (in_tuser == tpli_pkg::OP_CLEAR) begin
          have_first_r <= 1'b0;
        end else begin
          have_first_r <= !have_first_r;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_tuser == tpli_pkg::OP_CLEAR) begin
        fx_r <= '0;
        fy_r <= '0;
      end else if (!have_first_r) begin
        fx_r <= in_tdata[C-1:0];
        fy_r <= in_tdata[2*C-1:C];
      end else begin
        px_r <= in_tdata[C-1:0];
        py_r <= in_tdata[2*C-1:C];
      end
    end
    if (div_start) begin
      div_neg_r <= div_neg_nxt;
    end
    case (state_r)
      tpli_pkg::ST_CHK: begin
        uvert_r <= uvert;
        same_r  <= uvert && fvert;
        hit_r   <= 1'b0;
        cx_r    <= '0;
        cy_r    <= '0;
      end
      tpli_pkg::ST_S1:  if (div_stat.done) s1_r <= q_slope;
      tpli_pkg::ST_S2:  if (div_stat.done) s2_r <= q_slope;
      tpli_pkg::ST_CMP: same_r <= (s1_r == s2_r);
      tpli_pkg::ST_B1:  b1_r <= ic_b;
      tpli_pkg::ST_B2:  b2_r <= ic_b;
      tpli_pkg::ST_M4:  p1_r <= p_val;
      tpli_pkg::ST_NY: begin
        ny_neg_r <= ny_v[NW];
        ny_mag_r <= ny_v[NW] ? NW'(-ny_v) : ny_v[NW-1:0];
      end
      tpli_pkg::ST_CX:  if (div_stat.done) cx_r <= q_res;
      tpli_pkg::ST_CY: begin
        if (div_stat.done) begin
          cy_r  <= q_res;
          hit_r <= 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r                <= {cy_r, cx_r};
      out_flags_r.hit           <= hit_r;
      out_flags_r.user_vertical <= uvert_r;
      out_flags_r.same_slope    <= same_r;
    end
  end

  tpli_div #(
    .NW   (NW),
    .DW   (DW),
    .QW   (QW),
    .LENW (LENW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .len   (div_len),
    .q     (div_q),
    .stat  (div_stat)
  );

  tpli_mul #(
    .AW (SM),
    .BW (BW)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flags_r;

endmodule

// ===== rtl/tpli_chk.sv =====
// Port-level checker for the two-point line intersection block, with its bind.
module tpli_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [tpli_pkg::OUT_DW-1:0] out_tdata,
  input logic [tpli_pkg::OUT_UW-1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("missed intersection carries a nonzero point");

  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1] && !out_tuser[2])
    else $error("hit reported with vertical or parallel user line");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind two_point_line_intersection tpli_chk u_tpli_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
